// ----- rtl/core/prrts_pkg.sv -----
// Shared types and constants for the priority round-robin thread scheduler.
package prrts_pkg;

  // Default number of thread slots in the table.
  localparam int unsigned THREAD_SLOTS_DEF = 16;

  // Slot state codes; the fourth code is never written.
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_state_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_CREATED  = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_SWITCHED = 3'd2,
    STATUS_KEPT     = 3'd3,
    STATUS_DEADLOCK = 3'd4
  } status_t;

  // Request kinds.
  typedef enum logic {
    REQ_CREATE   = 1'b0,
    REQ_SCHEDULE = 1'b1
  } req_t;

  // What happens to the current slot on a schedule request.
  typedef enum logic {
    LEAVE_YIELD = 1'b0,
    LEAVE_EXIT  = 1'b1
  } leave_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    FSM_IDLE   = 3'd0,
    FSM_SCAN   = 3'd1,
    FSM_WR_CUR = 3'd2,
    FSM_WR_SEL = 3'd3,
    FSM_RESP   = 3'd4
  } fsm_t;

endpackage

// ----- rtl/core/priority_round_robin_thread_scheduler.sv -----
// Thread slot table with a priority scheduler that breaks ties round robin.
//
//  Channel  Direction  Ports                       Contents
//  request  in         s_tvalid s_tready           s_tuser: req_type
//                      s_tdata s_tuser             s_tdata: priority_req, leaving_state
//  result   out        m_tvalid m_tready m_tdata   m_tdata: status, slot
//
// A request scans the whole table through one read port, one slot per cycle.
// After the scan a create writes the free slot it found, if any, then the result;
// a schedule first writes back the current slot, then the slot it picked, if any.
// Reset takes effect at once: per-slot valid bits make unwritten slots read
// as their reset value, so no clearing pass is needed.
// A result that is not taken holds the block in its last step; a new request is
// accepted as soon as the result sits in the output register.
module priority_round_robin_thread_scheduler
  import prrts_pkg::*;
#(
  parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] priority_req, [8] leaving_state, rest zero
  input  logic [0:0]  s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [2:0] status, [6:3] slot, [7] zero
);

  localparam int unsigned IDX_W = $clog2(THREAD_SLOTS);
  localparam int unsigned CNT_W = $clog2(THREAD_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_SLOTS - 1);
  localparam logic [CNT_W-1:0] SCAN_LEN = CNT_W'(THREAD_SLOTS);

  fsm_t fsm, fsm_next;

  // Slot table storage and its valid bits.
  slot_state_t state_mem [THREAD_SLOTS];
  logic [7:0]  prio_mem  [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] entry_valid;

  // Captured request.
  req_t       req;
  logic [7:0] prio_new;
  leave_t     leaving;

  // Scan control and read pipeline.
  logic [IDX_W-1:0] current, rd_addr, rd_idx, best, start_addr;
  logic [CNT_W-1:0] cnt;
  logic             rd_vld, rd_ok, found, issue, eval, out_free;
  slot_state_t      rd_state, ent_state, cur_state, cur_after, cur_new;
  logic [7:0]       rd_prio, ent_prio, cur_prio, best_prio;

  // Write port.
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  slot_state_t      wr_state;
  logic [7:0]       wr_prio;

  // Result.
  status_t    res_status, m_status;
  logic [3:0] res_slot, m_slot;

  assign m_tdata  = {1'b0, m_slot, m_status};
  assign out_free = !m_tvalid || m_tready;
  assign issue    = (fsm == FSM_SCAN) && (cnt != SCAN_LEN);
  assign eval     = (fsm == FSM_SCAN) && rd_vld;

  // A create scans from slot zero; a schedule starts just after the current slot
  // so that the current slot is seen last.
  always_comb begin
    if (req_t'(s_tuser[0]) == REQ_CREATE) begin
      start_addr = '0;
    end else if (current == LAST_IDX) begin
      start_addr = '0;
    end else begin
      start_addr = current + 1'b1;
    end
  end

  // Slots never written read as their reset value.
  always_comb begin
    if (rd_ok) begin
      ent_state = rd_state;
      ent_prio  = rd_prio;
    end else begin
      ent_state = (rd_idx == '0) ? SLOT_RUNNING : SLOT_FREE;
      ent_prio  = '0;
    end
  end

  // Retirement of the current slot and the state it is finally written with.
  always_comb begin
    if (cur_state == SLOT_RUNNING) begin
      cur_after = (leaving == LEAVE_EXIT) ? SLOT_FREE : SLOT_RUNNABLE;
    end else begin
      cur_after = cur_state;
    end
    if (!found && cur_after == SLOT_RUNNABLE) begin
      cur_new = SLOT_RUNNING;
    end else begin
      cur_new = cur_after;
    end
  end

  // Result selection.
  always_comb begin
    res_status = STATUS_DEADLOCK;
    res_slot   = '0;
    if (req == REQ_CREATE) begin
      if (found) begin
        res_status = STATUS_CREATED;
        res_slot   = 4'(best);
      end else begin
        res_status = STATUS_FULL;
      end
    end else if (found) begin
      res_status = STATUS_SWITCHED;
      res_slot   = 4'(best);
    end else if (cur_after == SLOT_RUNNABLE) begin
      res_status = STATUS_KEPT;
      res_slot   = 4'(current);
    end
  end

  // Next state.
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      FSM_IDLE: begin
        if (s_tvalid) fsm_next = FSM_SCAN;
      end
      FSM_SCAN: begin
        if (cnt == SCAN_LEN) begin
          fsm_next = (req == REQ_SCHEDULE) ? FSM_WR_CUR : FSM_WR_SEL;
        end
      end
      FSM_WR_CUR: fsm_next = FSM_WR_SEL;
      FSM_WR_SEL: fsm_next = FSM_RESP;
      FSM_RESP: begin
        if (out_free) fsm_next = FSM_IDLE;
      end
      default: fsm_next = FSM_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and table write port.
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = best;
    wr_state = SLOT_RUNNING;
    wr_prio  = best_prio;
    unique case (fsm)
      FSM_IDLE: s_tready = 1'b1;
      FSM_SCAN: ;
      FSM_WR_CUR: begin
        mem_we   = 1'b1;
        wr_addr  = current;
        wr_state = cur_new;
        wr_prio  = cur_prio;
      end
      FSM_WR_SEL: begin
        mem_we = found;
        if (req == REQ_CREATE) begin
          wr_state = SLOT_RUNNABLE;
          wr_prio  = prio_new;
        end
      end
      FSM_RESP: ;
      default: ;
    endcase
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[wr_addr] <= wr_state;
      prio_mem[wr_addr]  <= wr_prio;
    end
    if (issue) begin
      rd_state <= state_mem[rd_addr];
      rd_prio  <= prio_mem[rd_addr];
      rd_ok    <= entry_valid[rd_addr];
      rd_idx   <= rd_addr;
    end
  end

  // Valid bits mark slots that have been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Captured request fields.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req      <= req_t'(s_tuser[0]);
      prio_new <= s_tdata[7:0];
      leaving  <= leave_t'(s_tdata[8]);
    end
  end

  // Scan evaluation: first free slot for create; for schedule the best runnable
  // other slot, while the current slot, seen last, is captured for retirement.
  always_ff @(posedge clk) begin
    if (eval) begin
      if (req == REQ_CREATE) begin
        if (!found && ent_state == SLOT_FREE) best <= rd_idx;
      end else if (rd_idx == current) begin
        cur_state <= ent_state;
        cur_prio  <= ent_prio;
      end else if (ent_state == SLOT_RUNNABLE && (!found || ent_prio < best_prio)) begin
        best      <= rd_idx;
        best_prio <= ent_prio;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm     <= FSM_IDLE;
      current <= '0;
      cnt     <= '0;
      rd_addr <= '0;
      rd_vld  <= 1'b0;
      found   <= 1'b0;
    end else begin
      fsm    <= fsm_next;
      rd_vld <= issue;
      if (s_tvalid && s_tready) begin
        cnt     <= '0;
        rd_addr <= start_addr;
        found   <= 1'b0;
      end
      if (issue) begin
        cnt     <= cnt + 1'b1;
        rd_addr <= (rd_addr == LAST_IDX) ? '0 : rd_addr + 1'b1;
      end
      if (eval) begin
        if (req == REQ_CREATE) begin
          if (ent_state == SLOT_FREE) found <= 1'b1;
        end else if (rd_idx != current && ent_state == SLOT_RUNNABLE) begin
          found <= 1'b1;
        end
      end
      if (fsm == FSM_WR_SEL && req == REQ_SCHEDULE && found) begin
        current <= best;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fsm == FSM_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == FSM_RESP && out_free) begin
      m_status <= res_status;
      m_slot   <= res_slot;
    end
  end

  // A transfer in starts a scan, so the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while a scan should be running");

  // The slot picked by a schedule is never the current slot.
  a_pick_other: assert property (@(posedge clk) disable iff (rst)
    (fsm == FSM_WR_CUR && found) |-> (best != current))
    else $error("schedule picked the current slot as another thread");

  // A deadlock result reports slot zero.
  a_deadlock_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_status == STATUS_DEADLOCK) |-> (m_slot == 4'd0))
    else $error("deadlock result with a nonzero slot");

  // A scan never issues more reads than the table has slots.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (fsm == FSM_SCAN) |-> (cnt <= SCAN_LEN))
    else $error("scan counter ran past the table");

endmodule
